>>> rtl/core/tesc_pkg.sv
// ----------------------------------------------------------------------------
// tesc_pkg
// Shared types, codes and helpers of the template escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tesc_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int CP_W = 21;
    localparam logic [24:0] CP_LIMIT = 25'h10FFFF;

    // everything one input produces: up to four data bytes and an end marker
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      ndata;
        logic            has_end;
        logic            end_err;
    } t_run;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      ndata;
    } t_utf8;

    function automatic t_hex hex_value(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.val = b[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic t_utf8 encode_utf8(input logic [CP_W-1:0] cp);
        t_utf8 e;
        e.data = '0;
        if (cp <= 21'h7F) begin
            e.data[0] = cp[7:0];
            e.ndata   = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.data[0] = {3'b110, cp[10:6]};
            e.data[1] = {2'b10, cp[5:0]};
            e.ndata   = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.data[0] = {4'b1110, cp[15:12]};
            e.data[1] = {2'b10, cp[11:6]};
            e.data[2] = {2'b10, cp[5:0]};
            e.ndata   = 3'd3;
        end else begin
            e.data[0] = {5'b11110, cp[20:18]};
            e.data[1] = {2'b10, cp[17:12]};
            e.data[2] = {2'b10, cp[11:6]};
            e.data[3] = {2'b10, cp[5:0]};
            e.ndata   = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/template_escape_to_utf8_core.sv
// ----------------------------------------------------------------------------
// template_escape_to_utf8_core
// Cooks template-literal text bytes: escape decoding with UTF-8 output.
// ----------------------------------------------------------------------------
// path: accepted run -> run queue -> emitter run register -> first result valid
// throughput: one input per cycle while the run queue has room; results leave
//   one per cycle while i_ready; the output rate is set by the single-result
//   emitter draining the run queue
// reset: synchronous active low, clears escape state, queue pointers and emitter
`default_nettype none

module template_escape_to_utf8_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_byte_present,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_out_kind,
    output logic            o_last_in_run
);

    tesc_pkg::t_run w_front_run;
    tesc_pkg::t_run w_head_run;
    logic           w_push;
    logic           w_pop;
    logic           w_head_valid;
    logic           w_full;
    logic           w_accept;

    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    tesc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .o_run          (w_front_run),
        .o_push         (w_push)
    );

    tesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_run   (w_front_run),
        .i_pop   (w_pop),
        .o_run   (w_head_run),
        .o_valid (w_head_valid),
        .o_full  (w_full)
    );

    tesc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_head_valid),
        .i_q_run       (w_head_run),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_kind    (o_out_kind),
        .o_last_in_run (o_last_in_run)
    );

endmodule

`default_nettype wire

>>> rtl/core/tesc_front.sv
// ----------------------------------------------------------------------------
// tesc_front
// Escape state machine: classifies each raw byte and builds its result run.
// ----------------------------------------------------------------------------
`default_nettype none

module tesc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_byte_present,
    input  wire logic           i_end_of_text,
    output tesc_pkg::t_run      o_run,
    output logic                o_push
);

    typedef enum logic [3:0] {
        M_PLAIN  = 4'd0,
        M_ESC    = 4'd1,
        M_CR     = 4'd2,
        M_ZERO   = 4'd3,
        M_E2     = 4'd4,
        M_E280   = 4'd5,
        M_HEXX   = 4'd6,
        M_USTART = 4'd7,
        M_UFOUR  = 4'd8,
        M_UBRACE = 4'd9
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LS0    = 8'hE2;
    localparam logic [7:0] CH_LS1    = 8'h80;
    localparam logic [7:0] CH_LS2    = 8'hA8;
    localparam logic [7:0] CH_PS2    = 8'hA9;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    t_mode                      r_mode,   n_mode;
    logic [tesc_pkg::CP_W-1:0]  r_acc,    n_acc;
    logic [1:0]                 r_cnt,    n_cnt;
    logic                       r_saw,    n_saw;
    logic                       r_failed, n_failed;

    logic [3:0][7:0]            v_bytes;
    logic [2:0]                 v_cnt;
    logic                       v_plain;
    logic                       v_end_err;
    tesc_pkg::t_hex             v_hex;
    tesc_pkg::t_utf8            v_enc;
    logic [24:0]                v_wide;

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_saw     = r_saw;
        n_failed  = r_failed;
        v_bytes   = '0;
        v_cnt     = 3'd0;
        v_plain   = 1'b0;
        v_end_err = 1'b0;
        v_hex     = tesc_pkg::hex_value(i_in_byte);
        v_wide    = {r_acc, v_hex.val};
        v_enc     = tesc_pkg::encode_utf8(r_acc);

        if (i_byte_present && !r_failed) begin
            unique case (r_mode)
                M_ESC: begin
                    n_mode = M_PLAIN;
                    unique case (i_in_byte)
                        CH_N: begin v_bytes[0] = 8'h0A; v_cnt = 3'd1; end
                        CH_T: begin v_bytes[0] = 8'h09; v_cnt = 3'd1; end
                        CH_R: begin v_bytes[0] = 8'h0D; v_cnt = 3'd1; end
                        CH_B: begin v_bytes[0] = 8'h08; v_cnt = 3'd1; end
                        CH_F: begin v_bytes[0] = 8'h0C; v_cnt = 3'd1; end
                        CH_V: begin v_bytes[0] = 8'h0B; v_cnt = 3'd1; end
                        CH_LF: begin end
                        CH_CR:   n_mode = M_CR;
                        CH_LS0:  n_mode = M_E2;
                        CH_ZERO: n_mode = M_ZERO;
                        CH_X: begin
                            n_mode = M_HEXX;
                            n_acc  = '0;
                            n_cnt  = 2'd0;
                        end
                        CH_U:    n_mode = M_USTART;
                        default: begin
                            if (tesc_pkg::is_digit(i_in_byte)) begin
                                n_failed = 1'b1;
                            end else begin
                                v_bytes[0] = i_in_byte;
                                v_cnt      = 3'd1;
                            end
                        end
                    endcase
                end
                M_CR: begin
                    if (i_in_byte == CH_LF) n_mode = M_PLAIN;
                    else                    v_plain = 1'b1;
                end
                M_ZERO: begin
                    if (tesc_pkg::is_digit(i_in_byte)) begin
                        n_failed = 1'b1;
                        n_mode   = M_PLAIN;
                    end else begin
                        v_bytes[0] = 8'h00;
                        v_cnt      = 3'd1;
                        v_plain    = 1'b1;
                    end
                end
                M_E2: begin
                    if (i_in_byte == CH_LS1) begin
                        n_mode = M_E280;
                    end else begin
                        v_bytes[0] = CH_LS0;
                        v_cnt      = 3'd1;
                        v_plain    = 1'b1;
                    end
                end
                M_E280: begin
                    if (i_in_byte == CH_LS2 || i_in_byte == CH_PS2) begin
                        n_mode = M_PLAIN;
                    end else begin
                        v_bytes[0] = CH_LS0;
                        v_bytes[1] = CH_LS1;
                        v_cnt      = 3'd2;
                        v_plain    = 1'b1;
                    end
                end
                M_HEXX: begin
                    if (!v_hex.ok) begin
                        n_failed = 1'b1;
                        n_mode   = M_PLAIN;
                    end else begin
                        n_acc = {13'd0, r_acc[3:0], v_hex.val};
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd1) begin
                            v_bytes[0] = {r_acc[3:0], v_hex.val};
                            v_cnt      = 3'd1;
                            n_mode     = M_PLAIN;
                        end
                    end
                end
                M_USTART: begin
                    if (i_in_byte == CH_LBRACE) begin
                        n_mode = M_UBRACE;
                        n_acc  = '0;
                        n_saw  = 1'b0;
                    end else if (!v_hex.ok) begin
                        n_failed = 1'b1;
                        n_mode   = M_PLAIN;
                    end else begin
                        n_mode = M_UFOUR;
                        n_acc  = {17'd0, v_hex.val};
                        n_cnt  = 2'd1;
                    end
                end
                M_UFOUR: begin
                    if (!v_hex.ok) begin
                        n_failed = 1'b1;
                        n_mode   = M_PLAIN;
                    end else begin
                        n_acc = {5'd0, r_acc[11:0], v_hex.val};
                        n_cnt = r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            v_enc   = tesc_pkg::encode_utf8({5'd0, r_acc[11:0], v_hex.val});
                            v_bytes = v_enc.data;
                            v_cnt   = v_enc.ndata;
                            n_mode  = M_PLAIN;
                        end
                    end
                end
                M_UBRACE: begin
                    if (i_in_byte == CH_RBRACE) begin
                        if (!r_saw) begin
                            n_failed = 1'b1;
                        end else begin
                            v_bytes = v_enc.data;
                            v_cnt   = v_enc.ndata;
                        end
                        n_mode = M_PLAIN;
                    end else if (!v_hex.ok) begin
                        n_failed = 1'b1;
                        n_mode   = M_PLAIN;
                    end else begin
                        n_saw = 1'b1;
                        n_acc = v_wide[tesc_pkg::CP_W-1:0];
                        // out of range code point
                        if (v_wide > tesc_pkg::CP_LIMIT) begin
                            n_failed = 1'b1;
                            n_mode   = M_PLAIN;
                        end
                    end
                end
                default: v_plain = 1'b1;
            endcase

            // byte handled as plain text after any pending prefix
            if (v_plain) begin
                if (i_in_byte == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    n_mode             = M_PLAIN;
                    v_bytes[v_cnt[1:0]] = i_in_byte;
                    v_cnt              = v_cnt + 3'd1;
                end
            end
        end

        if (i_end_of_text) begin
            v_end_err = n_failed;
            if (!n_failed) begin
                unique case (n_mode)
                    M_ZERO: begin
                        v_bytes[v_cnt[1:0]] = 8'h00;
                        v_cnt              = v_cnt + 3'd1;
                    end
                    M_E2: begin
                        v_bytes[v_cnt[1:0]] = CH_LS0;
                        v_cnt              = v_cnt + 3'd1;
                    end
                    M_E280: begin
                        v_bytes[v_cnt[1:0]] = CH_LS0;
                        v_cnt              = v_cnt + 3'd1;
                        v_bytes[v_cnt[1:0]] = CH_LS1;
                        v_cnt              = v_cnt + 3'd1;
                    end
                    M_ESC, M_HEXX, M_USTART, M_UFOUR, M_UBRACE: v_end_err = 1'b1;
                    default: begin end
                endcase
            end
            n_mode   = M_PLAIN;
            n_acc    = '0;
            n_cnt    = 2'd0;
            n_saw    = 1'b0;
            n_failed = 1'b0;
        end
    end

    assign o_run.data    = v_bytes;
    assign o_run.ndata   = v_cnt;
    assign o_run.has_end = i_end_of_text;
    assign o_run.end_err = v_end_err;
    assign o_push        = i_accept && ((v_cnt != 3'd0) || i_end_of_text);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_PLAIN;
            r_acc    <= '0;
            r_cnt    <= 2'd0;
            r_saw    <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_saw    <= n_saw;
            r_failed <= n_failed;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tesc_queue.sv
// ----------------------------------------------------------------------------
// tesc_queue
// Small queue of result runs between the escape front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tesc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tesc_pkg::t_run i_run,
    input  wire logic           i_pop,
    output tesc_pkg::t_run      o_run,
    output logic                o_valid,
    output logic                o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tesc_pkg::t_run r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           v_push;
    logic           v_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_run   = r_mem[r_rd_ptr];
    assign v_push  = i_push && !o_full;
    assign v_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (v_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (v_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (v_push && !v_pop) begin
                r_count <= r_count + CW'(1);
            end else if (v_pop && !v_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tesc_back.sv
// ----------------------------------------------------------------------------
// tesc_back
// Emitter: holds one run, hands out its results one per cycle while i_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tesc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire tesc_pkg::t_run i_q_run,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_out_kind,
    output logic                o_last_in_run
);

    tesc_pkg::t_run r_run;
    logic           r_busy;
    logic [2:0]     r_idx;
    logic [2:0]     v_total;
    logic           v_last;
    logic           v_is_data;

    assign v_total   = r_run.ndata + {2'd0, r_run.has_end};
    assign v_last    = (r_idx == v_total - 3'd1);
    assign v_is_data = (r_idx < r_run.ndata);

    // refill when idle or in the same cycle the current run's last result leaves
    assign o_q_pop = i_q_valid && (!r_busy || (i_ready && v_last));

    assign o_valid       = r_busy;
    assign o_last_in_run = v_last;
    assign o_out_byte    = v_is_data ? r_run.data[r_idx[1:0]] : 8'h00;
    assign o_out_kind    = v_is_data       ? tesc_pkg::KIND_DATA :
                           r_run.end_err   ? tesc_pkg::KIND_ERR  : tesc_pkg::KIND_OK;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_run <= i_q_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (r_busy && i_ready) begin
            if (v_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/template_escape_to_utf8_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// template_escape_to_utf8_core_tb
// Feeds a directed table and then random template text segments through the
// escape decoder, with random gaps on both handshakes and one long output
// stall, and checks every cooked byte and end marker against a decoder model
// that lives in the bench, or against the table's expected result for typed rows.
// ----------------------------------------------------------------------------

module template_escape_to_utf8_core_tb;

    localparam int ITEM_TARGET   = 320;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AFTER    = 40;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_PRINT     = 40;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_E2     = 8'hE2;
    localparam logic [7:0] CH_80     = 8'h80;
    localparam logic [7:0] CH_LS     = 8'hA8;
    localparam logic [7:0] CH_PS     = 8'hA9;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // n t r b f v, backslash, backquote, dollar
    localparam logic [7:0] SIMPLE_ESC [9] = '{8'h6E, 8'h74, 8'h72, 8'h62, 8'h66, 8'h76,
                                               8'h5C, 8'h60, 8'h24};

    typedef enum logic [3:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_CR,
        MODE_ZERO,
        MODE_E2,
        MODE_E280,
        MODE_HEX2,
        MODE_USTART,
        MODE_U4,
        MODE_UBRACE
    } t_esc_mode;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_cooked;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eot;
        logic       typed;
        logic [7:0] exp_data;
        logic [1:0] exp_kind;
    } t_stim;

    // typed rows carry their single expected result, the rest use the model
    localparam t_stim DIRECTED [26] = '{
        '{8'hFF,     1'b1, 1'b0, 1'b1, 8'hFF, tesc_pkg::KIND_DATA},
        '{8'h00,     1'b1, 1'b0, 1'b1, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"n",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"0",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"A",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_E2,     1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_80,     1'b1, 1'b1, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{8'h00,     1'b0, 1'b1, 1'b1, 8'h00, tesc_pkg::KIND_OK},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"u",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_LBRACE, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"1",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"0",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"F",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"F",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"f",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"F",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_RBRACE, 1'b1, 1'b1, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{CH_BSLASH, 1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"7",       1'b1, 1'b0, 1'b0, 8'h00, tesc_pkg::KIND_DATA},
        '{"x",       1'b1, 1'b1, 1'b1, 8'h00, tesc_pkg::KIND_ERR},
        '{CH_BSLASH, 1'b1, 1'b1, 1'b1, 8'h00, tesc_pkg::KIND_ERR}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_byte_present;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic [1:0] o_out_kind;
    logic       o_last_in_run;

    int cycle_cnt  = 0;
    int err_cnt    = 0;
    int result_cnt = 0;
    int real_items = 0;

    t_stim   stim_q[$];
    t_cooked cooked_q[$];
    t_cooked run_q[$];

    // decoder model state
    t_esc_mode   mode;
    logic [24:0] acc;
    logic [2:0]  ndig;
    logic        seen_digit;
    logic        failed;

    template_escape_to_utf8_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_out_kind     (o_out_kind),
        .o_last_in_run  (o_last_in_run)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    task automatic reset_decoder();
        mode       = MODE_PLAIN;
        acc        = '0;
        ndig       = '0;
        seen_digit = 1'b0;
        failed     = 1'b0;
    endtask

    task automatic emit(input logic [7:0] b, input logic [1:0] k);
        t_cooked c;
        if (run_q.size() < 5) begin
            c.data = b;
            c.kind = k;
            c.last = 1'b0;
            run_q.insert(run_q.size(), c);
        end
    endtask

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        if (b >= "0" && b <= "9") v = b - "0";
        else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
        else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
        else return 5'd0;
        return {1'b1, v[3:0]};
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic emit_utf8(input logic [20:0] cp);
        int          nb;
        logic [20:0] part;
        logic [7:0]  lead;
        nb = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        if (nb == 1) begin
            emit(cp[7:0], tesc_pkg::KIND_DATA);
        end else begin
            lead = (nb == 2) ? 8'hC0 : (nb == 3) ? 8'hE0 : 8'hF0;
            part = cp >> (6 * (nb - 1));
            emit(lead | part[7:0], tesc_pkg::KIND_DATA);
            for (int i = nb - 2; i >= 0; i--) begin
                part = cp >> (6 * i);
                emit(8'h80 | {2'b00, part[5:0]}, tesc_pkg::KIND_DATA);
            end
        end
    endtask

    task automatic set_failed();
        failed = 1'b1;
        mode   = MODE_PLAIN;
    endtask

    task automatic to_plain(input logic [7:0] b);
        mode = MODE_PLAIN;
        if (b == CH_BSLASH) mode = MODE_ESC;
        else emit(b, tesc_pkg::KIND_DATA);
    endtask

    // works out the results of one accepted transaction into run_q
    task automatic cook_item(input logic [7:0] b, input logic present, input logic eot);
        logic [4:0] hx;
        run_q.delete();
        hx = hex_nibble(b);
        if (present && !failed) begin
            case (mode)
                MODE_ESC: begin
                    mode = MODE_PLAIN;
                    case (b)
                        "n":       emit(8'h0A, tesc_pkg::KIND_DATA);
                        "t":       emit(8'h09, tesc_pkg::KIND_DATA);
                        "r":       emit(8'h0D, tesc_pkg::KIND_DATA);
                        "b":       emit(8'h08, tesc_pkg::KIND_DATA);
                        "f":       emit(8'h0C, tesc_pkg::KIND_DATA);
                        "v":       emit(8'h0B, tesc_pkg::KIND_DATA);
                        CH_LF:     ;
                        CH_CR:     mode = MODE_CR;
                        CH_E2:     mode = MODE_E2;
                        "0":       mode = MODE_ZERO;
                        "x": begin
                            mode = MODE_HEX2;
                            acc  = '0;
                            ndig = '0;
                        end
                        "u":       mode = MODE_USTART;
                        default: begin
                            if (is_dec(b)) set_failed();
                            else emit(b, tesc_pkg::KIND_DATA);
                        end
                    endcase
                end
                MODE_CR: begin
                    if (b == CH_LF) mode = MODE_PLAIN;
                    else to_plain(b);
                end
                MODE_ZERO: begin
                    if (is_dec(b)) begin
                        set_failed();
                    end else begin
                        emit(8'h00, tesc_pkg::KIND_DATA);
                        to_plain(b);
                    end
                end
                MODE_E2: begin
                    if (b == CH_80) begin
                        mode = MODE_E280;
                    end else begin
                        emit(CH_E2, tesc_pkg::KIND_DATA);
                        to_plain(b);
                    end
                end
                MODE_E280: begin
                    if (b == CH_LS || b == CH_PS) begin
                        mode = MODE_PLAIN;
                    end else begin
                        emit(CH_E2, tesc_pkg::KIND_DATA);
                        emit(CH_80, tesc_pkg::KIND_DATA);
                        to_plain(b);
                    end
                end
                MODE_HEX2: begin
                    if (!hx[4]) begin
                        set_failed();
                    end else begin
                        acc  = ((acc << 4) | {21'd0, hx[3:0]}) & 25'hFF;
                        ndig = ndig + 3'd1;
                        if (ndig >= 3'd2) begin
                            emit(acc[7:0], tesc_pkg::KIND_DATA);
                            mode = MODE_PLAIN;
                        end
                    end
                end
                MODE_USTART: begin
                    if (b == CH_LBRACE) begin
                        mode       = MODE_UBRACE;
                        acc        = '0;
                        seen_digit = 1'b0;
                    end else if (!hx[4]) begin
                        set_failed();
                    end else begin
                        mode = MODE_U4;
                        acc  = {21'd0, hx[3:0]};
                        ndig = 3'd1;
                    end
                end
                MODE_U4: begin
                    if (!hx[4]) begin
                        set_failed();
                    end else begin
                        acc  = ((acc << 4) | {21'd0, hx[3:0]}) & 25'hFFFF;
                        ndig = ndig + 3'd1;
                        if (ndig >= 3'd4) begin
                            emit_utf8(acc[20:0]);
                            mode = MODE_PLAIN;
                        end
                    end
                end
                MODE_UBRACE: begin
                    if (b == CH_RBRACE) begin
                        if (!seen_digit) begin
                            set_failed();
                        end else begin
                            emit_utf8(acc[20:0]);
                            mode = MODE_PLAIN;
                        end
                    end else if (!hx[4]) begin
                        set_failed();
                    end else begin
                        seen_digit = 1'b1;
                        acc        = (acc << 4) | {21'd0, hx[3:0]};
                        if (acc > tesc_pkg::CP_LIMIT) set_failed();
                    end
                end
                default: to_plain(b);
            endcase
        end
        if (eot) begin
            if (!failed) begin
                case (mode)
                    MODE_ZERO: emit(8'h00, tesc_pkg::KIND_DATA);
                    MODE_E2:   emit(CH_E2, tesc_pkg::KIND_DATA);
                    MODE_E280: begin
                        emit(CH_E2, tesc_pkg::KIND_DATA);
                        emit(CH_80, tesc_pkg::KIND_DATA);
                    end
                    MODE_ESC, MODE_HEX2, MODE_USTART, MODE_U4, MODE_UBRACE: failed = 1'b1;
                    default: ;
                endcase
            end
            emit(8'h00, failed ? tesc_pkg::KIND_ERR : tesc_pkg::KIND_OK);
            reset_decoder();
        end
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // random segment generation
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input logic present, input logic eot);
        t_stim s;
        s         = '0;
        s.data    = b;
        s.present = present;
        s.eot     = eot;
        stim_q.insert(stim_q.size(), s);
        if (present || eot) real_items++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_item(b, 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
    endfunction

    task automatic add_hex(input logic [24:0] v, input int n);
        logic [24:0] nib;
        for (int i = n - 1; i >= 0; i--) begin
            nib = v >> (4 * i);
            add_byte(hex_char(nib[3:0]));
        end
    endtask

    // a byte that breaks a hex escape without opening or closing a brace
    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] hx;
        do begin
            b  = 8'($urandom_range(0, 255));
            hx = hex_nibble(b);
        end while (hx[4] || b == CH_LBRACE || b == CH_RBRACE);
        return b;
    endfunction

    task automatic add_token();
        int          r;
        int          n;
        logic [24:0] cp;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            add_byte(8'($urandom_range(0, 255)));
        end else if (r < 42) begin
            add_byte(CH_BSLASH);
            add_byte(SIMPLE_ESC[$urandom_range(0, 8)]);
        end else if (r < 47) begin
            add_byte(CH_BSLASH);
            add_byte(8'($urandom_range(0, 255)));
        end else if (r < 54) begin
            add_byte(CH_BSLASH);
            case ($urandom_range(0, 4))
                0: add_byte(CH_LF);
                1: add_byte(CH_CR);
                2: begin
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                end
                default: begin
                    add_byte(CH_E2);
                    add_byte(CH_80);
                    add_byte($urandom_range(0, 1) ? CH_LS : CH_PS);
                end
            endcase
        end else if (r < 60) begin
            // pending sequences, resolved by whatever comes next
            add_byte(CH_BSLASH);
            case ($urandom_range(0, 2))
                0: add_byte("0");
                1: add_byte(CH_E2);
                default: begin
                    add_byte(CH_E2);
                    add_byte(CH_80);
                end
            endcase
        end else if (r < 66) begin
            add_byte(CH_BSLASH);
            add_byte("x");
            add_hex(25'($urandom_range(0, 255)), 2);
        end else if (r < 74) begin
            add_byte(CH_BSLASH);
            add_byte("u");
            add_hex(25'($urandom_range(0, 16'hFFFF)), 4);
        end else if (r < 84) begin
            case ($urandom_range(0, 3))
                0: cp = 25'($urandom_range(0, 8'h7F));
                1: cp = 25'($urandom_range(8'h80, 11'h7FF));
                2: cp = 25'($urandom_range(12'h800, 16'hFFFF));
                default: cp = 25'($urandom_range(17'h10000, 21'h10FFFF));
            endcase
            n = 1;
            while ((cp >> (4 * n)) != 0) n++;
            add_byte(CH_BSLASH);
            add_byte("u");
            add_byte(CH_LBRACE);
            add_hex(cp, n + $urandom_range(0, 1));
            add_byte(CH_RBRACE);
        end else begin
            add_byte(CH_BSLASH);
            case ($urandom_range(0, 7))
                0: add_byte(8'(8'h31 + $urandom_range(0, 8)));
                1: begin
                    add_byte("0");
                    add_byte(8'(8'h30 + $urandom_range(0, 9)));
                end
                2: begin
                    add_byte("x");
                    add_hex(25'($urandom_range(0, 15)), $urandom_range(0, 1));
                    add_byte(non_hex_byte());
                end
                3: begin
                    add_byte("u");
                    add_hex(25'($urandom_range(0, 255)), $urandom_range(0, 3));
                    add_byte(non_hex_byte());
                end
                4: begin
                    add_byte("u");
                    add_byte(CH_LBRACE);
                    add_byte(CH_RBRACE);
                end
                5: begin
                    add_byte("u");
                    add_byte(CH_LBRACE);
                    add_hex(25'($urandom_range(0, 15)), $urandom_range(0, 2));
                    add_byte(non_hex_byte());
                end
                6: begin
                    add_byte("u");
                    add_byte(CH_LBRACE);
                    add_hex(25'($urandom_range(25'h110000, 25'hFFFFFF)), 6);
                    add_byte(CH_RBRACE);
                end
                default: begin
                    // segment cut off inside an escape
                    case ($urandom_range(0, 3))
                        0: ;
                        1: begin
                            add_byte("x");
                            add_hex(25'($urandom_range(0, 15)), $urandom_range(0, 1));
                        end
                        2: begin
                            add_byte("u");
                            add_hex(25'($urandom_range(0, 16'hFFF)), $urandom_range(0, 3));
                        end
                        default: begin
                            add_byte("u");
                            add_byte(CH_LBRACE);
                            add_hex(25'($urandom_range(0, 16'hFFF)), $urandom_range(0, 3));
                        end
                    endcase
                    stim_q[stim_q.size() - 1].eot = 1'b1;
                end
            endcase
        end
        if ($urandom_range(0, 24) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    task automatic add_segment();
        int ntok;
        ntok = $urandom_range(1, 10);
        repeat (ntok) add_token();
        if ($urandom_range(0, 1)) stim_q[stim_q.size() - 1].eot = 1'b1;
        else add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < MAX_PRINT) begin
            $display("tb: %s mismatch at result %0d, cycle %0d: got %0h want %0h",
                     what, result_cnt, cycle_cnt, got, want);
        end
        err_cnt++;
    endtask

    task automatic check_result();
        t_cooked want;
        if (cooked_q.size() == 0) begin
            report_mismatch("unexpected result", o_out_byte, 0);
        end else begin
            want = cooked_q.pop_front();
            if (o_out_kind !== want.kind) report_mismatch("out_kind", o_out_kind, want.kind);
            if (o_out_byte !== want.data) report_mismatch("out_byte", o_out_byte, want.data);
            if (o_last_in_run !== want.last) begin
                report_mismatch("last_in_run", o_last_in_run, want.last);
            end
        end
        result_cnt++;
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    initial begin
        int    gap;
        bit    burst;
        t_stim it;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_in_byte      = 8'h00;
        i_byte_present = 1'b0;
        i_end_of_text  = 1'b0;
        burst          = 1'b0;
        reset_decoder();
        foreach (DIRECTED[i]) stim_q.insert(stim_q.size(), DIRECTED[i]);
        while (real_items < ITEM_TARGET) add_segment();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_q[k]) begin
            it  = stim_q[k];
            gap = burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 24) == 0) burst = !burst;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid        <= 1'b1;
            i_in_byte      <= it.data;
            i_byte_present <= it.present;
            i_end_of_text  <= it.eot;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            cook_item(it.data, it.present, it.eot);
            if (it.typed) begin
                cooked_q.insert(cooked_q.size(), t_cooked'{it.exp_data, it.exp_kind, 1'b1});
            end else begin
                foreach (run_q[j]) cooked_q.insert(cooked_q.size(), run_q[j]);
            end
            @(negedge i_clk);
        end
        i_valid <= 1'b0;

        while (cooked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    initial begin
        int gap;
        bit burst;
        bit held;
        i_ready = 1'b0;
        burst   = 1'b0;
        held    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 24) == 0) burst = !burst;
            // one long stall so the run queue fills and backs up the input
            if (result_cnt >= HOLD_AFTER && !held) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            check_result();
            @(negedge i_clk);
        end
    end

endmodule
